>>> hw/rtl/bffpa_pkg.sv
package bffpa_pkg;

  // field widths of the command and result transfers, and the map word width
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned WORD_W  = 32;

  // default geometry of the zone
  localparam int unsigned DEF_ZONE_PAGES = 1024;
  localparam int unsigned DEF_PAGE_SHIFT = 12;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_e;

  // command transfer
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COUNT_W-1:0] page_count;
    logic [ADDR_W-1:0]  free_address;
  } req_t;

  // result transfer
  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] result_address;
  } rsp_t;

  // per-word evaluation controls
  typedef struct packed {
    logic [WORD_W-1:0] valid_mask;
    logic [WORD_W-1:0] win_mask;
    logic [4:0]        lo;
    logic [4:0]        hi;
  } eval_ctl_t;

  // per-word evaluation results
  typedef struct packed {
    logic              all_free;
    logic              any_free;
    logic [4:0]        free_pos;
    logic [5:0]        trail;
    logic [5:0]        lead;
    logic              win_any;
    logic [4:0]        win_pos;
    logic              covered;
    logic [WORD_W-1:0] set_word;
    logic [WORD_W-1:0] clr_word;
  } eval_t;

endpackage

>>> hw/rtl/bffpa_map_ram.sv
module bffpa_map_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [bffpa_pkg::WORD_W-1:0]  wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [bffpa_pkg::WORD_W-1:0]  rdata_o
);

  logic [bffpa_pkg::WORD_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hw/rtl/bffpa_word_eval.sv
module bffpa_word_eval (
  input  logic [bffpa_pkg::WORD_W-1:0] word_i,
  input  bffpa_pkg::eval_ctl_t         ctl_i,
  output bffpa_pkg::eval_t             ev_o
);

  localparam int unsigned W = bffpa_pkg::WORD_W;

  logic [W-1:0]   free_w;
  logic [2*W-1:0] used_ext;
  logic [W-1:0]   win_hit;
  logic [W-1:0]   rng_mask;

  // free bits, pages past the zone count as used
  assign free_w   = ~word_i & ctl_i.valid_mask;
  assign used_ext = {{W{1'b1}}, ~free_w};

  // window lanes: lane i hits when the window starting at bit i is all free
  always_comb begin
    for (int i = 0; i < W; i++) begin
      win_hit[i] = (|ctl_i.win_mask) && !(|(used_ext[i +: W] & ctl_i.win_mask));
    end
  end

  // bit range lo..hi of a mark or check pass
  assign rng_mask = ({W{1'b1}} << ctl_i.lo) & ({W{1'b1}} >> (5'd31 - ctl_i.hi));

  // priority encoders
  always_comb begin
    ev_o          = '0;
    ev_o.all_free = &free_w;
    ev_o.any_free = |free_w;
    ev_o.win_any  = |win_hit;
    ev_o.trail    = 6'd32;
    ev_o.lead     = 6'd32;
    for (int i = W - 1; i >= 0; i--) begin
      if (free_w[i]) begin
        ev_o.free_pos = 5'(i);
      end
      if (win_hit[i]) begin
        ev_o.win_pos = 5'(i);
      end
      if (!free_w[i]) begin
        ev_o.trail = 6'(i);
      end
    end
    for (int i = 0; i < W; i++) begin
      if (!free_w[i]) begin
        ev_o.lead = 6'(W - 1 - i);
      end
    end
    ev_o.covered  = (word_i & rng_mask) == rng_mask;
    ev_o.set_word = word_i | rng_mask;
    ev_o.clr_word = word_i & ~rng_mask;
  end

endmodule

>>> hw/rtl/bitmap_first_fit_page_allocator.sv
// channel   | signals                    | transfer condition
// ----------+----------------------------+-----------------------------
// command   | start, busy, req_i         | start high while busy low
// result    | done_o, rsp_o              | done_o high, one cycle only
// config    | cfg_we_i, cfg_wdata_i      | cfg_we_i high
//
// After reset the used map is cleared one word a cycle with busy high. Each item reads the
// map one word a cycle through the single read port, so its length follows the words it
// touches: a query scans up to every map word, an allocate the scanned plus the marked
// words, a free its range in words twice. One result per item; the receiver cannot stall
// it, and a new command is taken in the same cycle as the previous result.
module bitmap_first_fit_page_allocator #(
  parameter int unsigned ZONE_PAGES = bffpa_pkg::DEF_ZONE_PAGES,
  parameter int unsigned PAGE_SHIFT = bffpa_pkg::DEF_PAGE_SHIFT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bffpa_pkg::req_t               req_i,
  output logic                          done_o,
  output bffpa_pkg::rsp_t               rsp_o,
  input  logic                          cfg_we_i,
  input  logic [bffpa_pkg::ADDR_W-1:0]  cfg_wdata_i
);

  localparam int unsigned MAP_WORDS = (ZONE_PAGES + 31) / 32;
  localparam int unsigned WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned PIW       = WW + 5;
  localparam int unsigned PW        = $clog2(ZONE_PAGES + 1);
  localparam int unsigned CMPW      =
    ((PW > bffpa_pkg::COUNT_W) ? PW : bffpa_pkg::COUNT_W) + 1;
  localparam int unsigned AW        = bffpa_pkg::ADDR_W;
  localparam int unsigned W         = bffpa_pkg::WORD_W;
  localparam int unsigned TAIL      = ZONE_PAGES % 32;
  localparam logic [W-1:0] LAST_MASK =
    (TAIL == 0) ? {W{1'b1}} : W'((64'd1 << TAIL) - 64'd1);
  localparam logic [WW-1:0] LAST_WORD     = WW'(MAP_WORDS - 1);
  localparam logic [AW-1:0] ZONE_BYTES_M1 =
    AW'((64'(ZONE_PAGES) << PAGE_SHIFT) - 64'd1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RANGE,
    S_SCAN,
    S_SETUP,
    S_CHECK,
    S_MARK,
    S_QADDR
  } state_e;

  state_e                 state_q;
  bffpa_pkg::req_t        req_q;
  bffpa_pkg::rsp_t        rsp_q;
  logic                   done_q;
  logic [AW-1:0]          zone_base_q;
  logic [WW-1:0]          ptr_q;
  logic                   issue_q;
  logic                   dv_q;
  logic                   dlast_q;
  logic [WW-1:0]          dw_q;
  logic                   is_alloc_q;
  logic                   none_q;
  logic [PW-1:0]          run_q;
  logic [PIW-1:0]         start_q;
  logic [PIW-1:0]         rng_first_q;
  logic [PIW-1:0]         rng_last_q;
  logic [W-1:0]           win_mask_q;
  logic [AW-1:0]          off_q;
  logic                   below_q;
  logic [AW-1:0]          addr_q;

  logic [WW-1:0]          end_word;
  logic                   mem_we;
  logic [WW-1:0]          mem_waddr;
  logic [W-1:0]           mem_wdata;
  logic [W-1:0]           mem_rdata;
  bffpa_pkg::eval_ctl_t   ev_ctl;
  bffpa_pkg::eval_t       ev;
  logic [CMPW-1:0]        run_sum;
  logic                   hit_carry;
  logic [PIW-1:0]         scan_base;
  logic [AW-1:0]          first_full;
  logic [AW:0]            end_excl;
  logic [AW:0]            last_full;
  logic [AW-1:0]          page_addr;
  logic [PIW-1:0]         alloc_last;

  // map storage
  bffpa_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (WW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue_q),
    .raddr_i (ptr_q),
    .rdata_o (mem_rdata)
  );

  // word evaluation of the data that just came back
  always_comb begin
    ev_ctl.valid_mask = (dw_q == LAST_WORD) ? LAST_MASK : {W{1'b1}};
    ev_ctl.win_mask   = win_mask_q;
    ev_ctl.lo         = (dw_q == rng_first_q[PIW-1:5]) ? rng_first_q[4:0] : 5'd0;
    ev_ctl.hi         = (dw_q == rng_last_q[PIW-1:5]) ? rng_last_q[4:0] : 5'd31;
  end

  bffpa_word_eval u_eval (
    .word_i (mem_rdata),
    .ctl_i  (ev_ctl),
    .ev_o   (ev)
  );

  // write port: clearing sweep or read-modify-write of a mark pass
  always_comb begin
    mem_we    = (state_q == S_CLEAR) || ((state_q == S_MARK) && dv_q);
    mem_waddr = (state_q == S_CLEAR) ? ptr_q : dw_q;
    if (state_q == S_CLEAR) begin
      mem_wdata = '0;
    end else if (is_alloc_q) begin
      mem_wdata = ev.set_word;
    end else begin
      mem_wdata = ev.clr_word;
    end
  end

  // scan and range arithmetic
  assign end_word   = (state_q == S_SCAN) ? LAST_WORD : rng_last_q[PIW-1:5];
  assign run_sum    = CMPW'(run_q) + CMPW'(ev.trail);
  assign hit_carry  = run_sum >= CMPW'(req_q.page_count);
  assign scan_base  = {dw_q, 5'd0};
  assign first_full = off_q >> PAGE_SHIFT;
  assign end_excl   = {1'b0, first_full} + (AW + 1)'(req_q.page_count);
  assign last_full  = end_excl - 1'b1;
  assign page_addr  = zone_base_q + AW'(64'(rng_first_q) << PAGE_SHIFT);
  assign alloc_last = PIW'(CMPW'(rng_first_q) + CMPW'(req_q.page_count) - 1'b1);

  // zone base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_base_q <= '0;
    end else if (cfg_we_i) begin
      zone_base_q <= cfg_wdata_i;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      done_q      <= 1'b0;
      rsp_q       <= '0;
      req_q       <= '0;
      ptr_q       <= '0;
      issue_q     <= 1'b0;
      dv_q        <= 1'b0;
      dlast_q     <= 1'b0;
      dw_q        <= '0;
      is_alloc_q  <= 1'b0;
      none_q      <= 1'b0;
      run_q       <= '0;
      start_q     <= '0;
      rng_first_q <= '0;
      rng_last_q  <= '0;
      win_mask_q  <= '0;
      off_q       <= '0;
      below_q     <= 1'b0;
      addr_q      <= '0;
    end else begin
      done_q <= 1'b0;
      dv_q   <= 1'b0;

      // word fetch, one read a cycle
      if (issue_q) begin
        ptr_q   <= ptr_q + 1'b1;
        issue_q <= (ptr_q != end_word);
        dv_q    <= 1'b1;
        dw_q    <= ptr_q;
        dlast_q <= (ptr_q == end_word);
      end

      case (state_q)
        S_CLEAR: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == LAST_WORD) begin
            ptr_q   <= '0;
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            req_q   <= req_i;
            state_q <= S_DECODE;
          end
        end

        S_DECODE: begin
          case (req_q.command)
            bffpa_pkg::CMD_ALLOC: begin
              if (req_q.page_count == '0) begin
                done_q  <= 1'b1;
                rsp_q   <= '{bffpa_pkg::ST_IGNORED, '0};
                state_q <= S_IDLE;
              end else begin
                is_alloc_q <= 1'b1;
                run_q      <= '0;
                ptr_q      <= '0;
                issue_q    <= 1'b1;
                win_mask_q <= (req_q.page_count <= bffpa_pkg::COUNT_W'(W)) ?
                              W'((64'd1 << req_q.page_count[5:0]) - 64'd1) : '0;
                state_q    <= S_SCAN;
              end
            end
            bffpa_pkg::CMD_FREE: begin
              if (req_q.free_address == '0 || req_q.page_count == '0) begin
                done_q  <= 1'b1;
                rsp_q   <= '{bffpa_pkg::ST_IGNORED, '0};
                state_q <= S_IDLE;
              end else begin
                is_alloc_q <= 1'b0;
                below_q    <= req_q.free_address < zone_base_q;
                off_q      <= req_q.free_address - zone_base_q;
                state_q    <= S_RANGE;
              end
            end
            bffpa_pkg::CMD_QUERY: begin
              is_alloc_q <= 1'b0;
              win_mask_q <= '0;
              ptr_q      <= '0;
              issue_q    <= 1'b1;
              state_q    <= S_SCAN;
            end
            default: begin
              done_q  <= 1'b1;
              rsp_q   <= '{bffpa_pkg::ST_IGNORED, '0};
              state_q <= S_IDLE;
            end
          endcase
        end

        // free: zone bounds
        S_RANGE: begin
          if (below_q || end_excl > (AW + 1)'(ZONE_PAGES)) begin
            done_q  <= 1'b1;
            rsp_q   <= '{bffpa_pkg::ST_OUTSIDE, '0};
            state_q <= S_IDLE;
          end else begin
            rng_first_q <= first_full[PIW-1:0];
            rng_last_q  <= last_full[PIW-1:0];
            ptr_q       <= first_full[PIW-1:5];
            issue_q     <= 1'b1;
            state_q     <= S_CHECK;
          end
        end

        // allocate: first-fit run search; query: first free page
        S_SCAN: begin
          if (dv_q) begin
            if (is_alloc_q) begin
              if (hit_carry || ev.win_any) begin
                if (hit_carry) begin
                  rng_first_q <= (run_q == '0) ? scan_base : start_q;
                end else begin
                  rng_first_q <= {dw_q, ev.win_pos};
                end
                issue_q <= 1'b0;
                dv_q    <= 1'b0;
                state_q <= S_SETUP;
              end else if (dlast_q) begin
                done_q  <= 1'b1;
                rsp_q   <= '{bffpa_pkg::ST_NO_SPACE, '0};
                state_q <= S_IDLE;
              end else if (ev.all_free) begin
                run_q <= PW'(run_q + PW'(W));
                if (run_q == '0) begin
                  start_q <= scan_base;
                end
              end else begin
                run_q   <= PW'(ev.lead);
                start_q <= PIW'(scan_base + PIW'(6'd32 - ev.lead));
              end
            end else begin
              if (ev.any_free) begin
                rng_first_q <= {dw_q, ev.free_pos};
                none_q      <= 1'b0;
                issue_q     <= 1'b0;
                dv_q        <= 1'b0;
                state_q     <= S_QADDR;
              end else if (dlast_q) begin
                none_q  <= 1'b1;
                state_q <= S_QADDR;
              end
            end
          end
        end

        S_SETUP: begin
          rng_last_q <= alloc_last;
          addr_q     <= page_addr;
          ptr_q      <= rng_first_q[PIW-1:5];
          issue_q    <= 1'b1;
          state_q    <= S_MARK;
        end

        // free: every page of the range must be in use
        S_CHECK: begin
          if (dv_q) begin
            if (!ev.covered) begin
              issue_q <= 1'b0;
              dv_q    <= 1'b0;
              done_q  <= 1'b1;
              rsp_q   <= '{bffpa_pkg::ST_NOT_ALLOC, '0};
              state_q <= S_IDLE;
            end else if (dlast_q) begin
              ptr_q   <= rng_first_q[PIW-1:5];
              issue_q <= 1'b1;
              state_q <= S_MARK;
            end
          end
        end

        // set or clear pass, write-back happens in the write port logic
        S_MARK: begin
          if (dv_q && dlast_q) begin
            done_q  <= 1'b1;
            rsp_q   <= '{bffpa_pkg::ST_OK, is_alloc_q ? addr_q : '0};
            state_q <= S_IDLE;
          end
        end

        S_QADDR: begin
          done_q  <= 1'b1;
          rsp_q   <= '{bffpa_pkg::ST_OK,
                       none_q ? zone_base_q + ZONE_BYTES_M1 : page_addr};
          state_q <= S_IDLE;
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // the map is never written between items
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we)
    else $error("map written while idle");

  // a result only closes work that was in progress
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a command in progress");

  // one result per command, never two in a row
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back results");

  // a fetch never runs outside the scan, check and mark passes
  a_fetch_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_q |-> (state_q == S_SCAN || state_q == S_CHECK || state_q == S_MARK))
    else $error("map read issued outside a pass");

endmodule
